// File: design/lcdnw_pkg.sv
package lcdnw_pkg;

    // Request codes
    localparam logic [2:0] OP_COMMAND = 3'd0;
    localparam logic [2:0] OP_DATA    = 3'd1;
    localparam logic [2:0] OP_INIT    = 3'd2;
    localparam logic [2:0] OP_SETPOS  = 3'd3;
    localparam logic [2:0] OP_CLEAR   = 3'd4;

    // Port write steps within one byte
    localparam logic [2:0] STEP_HI_NIBBLE = 3'd0;
    localparam logic [2:0] STEP_RS        = 3'd1;
    localparam logic [2:0] STEP_EN_HI_A   = 3'd2;
    localparam logic [2:0] STEP_EN_LO_A   = 3'd3;
    localparam logic [2:0] STEP_LO_NIBBLE = 3'd4;
    localparam logic [2:0] STEP_EN_HI_B   = 3'd5;
    localparam logic [2:0] STEP_EN_LO_B   = 3'd6;

    // Hold times in microseconds
    localparam logic [14:0] WAIT_NONE     = 15'd0;
    localparam logic [14:0] WAIT_PULSE    = 15'd1;
    localparam logic [14:0] WAIT_NIBBLE   = 15'd200;
    localparam logic [14:0] WAIT_BYTE     = 15'd2000;
    localparam logic [14:0] WAIT_CLEAR    = 15'd4000;
    localparam logic [14:0] WAIT_POWER_ON = 15'd20000;

    // Display command bytes
    localparam logic [7:0] CMD_CLEAR     = 8'h01;
    localparam logic [7:0] CMD_HOME_ROW0 = 8'h80;
    localparam logic [7:0] CMD_HOME_ROW1 = 8'hC0;
    localparam logic [7:0] NIBBLE_MASK   = 8'hF0;
    localparam logic [7:0] LOW_MASK      = 8'h0F;

    localparam int RS_BIT_DEFAULT = 0;
    localparam int EN_BIT_DEFAULT = 1;

    typedef struct packed {
        logic [2:0] operation;
        logic [7:0] value;
        logic       row;
        logic [3:0] column;
    } lcd_req_t;

    typedef struct packed {
        logic [7:0]  port_value;
        logic [14:0] wait_us;
        logic        last;
    } lcd_wr_t;

    // Controller to datapath
    typedef struct packed {
        logic       load;
        logic       emit;
        logic       power;
        logic [2:0] op;
        logic [2:0] byte_idx;
        logic [2:0] step;
        logic       last;
    } lcdnw_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic slot_free;
    } lcdnw_stat_t;

    function automatic logic [7:0] init_byte(input logic [2:0] idx);
        logic [7:0] b;
        case (idx)
            3'd0:    b = 8'h33;
            3'd1:    b = 8'h32;
            3'd2:    b = 8'h28;
            3'd3:    b = 8'h0C;
            3'd4:    b = 8'h06;
            3'd5:    b = CMD_CLEAR;
            default: b = CMD_HOME_ROW0;
        endcase
        return b;
    endfunction

    // Number of bytes sent by a request, minus one
    function automatic logic [2:0] last_byte_idx(input logic [2:0] op);
        logic [2:0] n;
        case (op)
            OP_INIT:  n = 3'd6;
            OP_CLEAR: n = 3'd1;
            default:  n = 3'd0;
        endcase
        return n;
    endfunction

endpackage

// File: design/lcdnw_ctrl.sv
module lcdnw_ctrl
    import lcdnw_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        req_valid,
    input  logic [2:0]  req_op,
    output logic        req_ready,
    input  lcdnw_stat_t stat,
    output lcdnw_cmd_t  cmd
);

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_POWER = 2'd1;
    localparam logic [1:0] ST_SEND  = 2'd2;

    logic [1:0] state_reg, state_next;
    logic [2:0] op_reg, op_next;
    logic [2:0] idx_reg, idx_next;
    logic [2:0] step_reg, step_next;
    logic       load;
    logic       final_byte;

    assign req_ready  = (state_reg == ST_IDLE);
    assign load       = req_valid && req_ready;
    assign final_byte = (idx_reg == last_byte_idx(op_reg));

    // Walk the power-on write, then bytes and steps
    always_comb
    begin
        state_next = state_reg;
        op_next    = op_reg;
        idx_next   = idx_reg;
        step_next  = step_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (load)
                begin
                    op_next   = req_op;
                    idx_next  = 3'd0;
                    step_next = STEP_HI_NIBBLE;
                    if (req_op == OP_INIT)
                        state_next = ST_POWER;
                    else if (req_op == OP_COMMAND || req_op == OP_DATA ||
                             req_op == OP_SETPOS || req_op == OP_CLEAR)
                        state_next = ST_SEND;
                end
            end
            ST_POWER:
            begin
                if (stat.slot_free)
                    state_next = ST_SEND;
            end
            ST_SEND:
            begin
                if (stat.slot_free)
                begin
                    if (step_reg == STEP_EN_LO_B)
                    begin
                        step_next = STEP_HI_NIBBLE;
                        if (final_byte)
                            state_next = ST_IDLE;
                        else
                            idx_next = idx_reg + 3'd1;
                    end
                    else
                    begin
                        step_next = step_reg + 3'd1;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            op_reg    <= OP_COMMAND;
            idx_reg   <= 3'd0;
            step_reg  <= STEP_HI_NIBBLE;
        end
        else
        begin
            state_reg <= state_next;
            op_reg    <= op_next;
            idx_reg   <= idx_next;
            step_reg  <= step_next;
        end
    end

    // Drive the datapath
    always_comb
    begin
        cmd.load     = load;
        cmd.emit     = stat.slot_free &&
                       (state_reg == ST_POWER || state_reg == ST_SEND);
        cmd.power    = (state_reg == ST_POWER);
        cmd.op       = op_reg;
        cmd.byte_idx = idx_reg;
        cmd.step     = step_reg;
        cmd.last     = (state_reg == ST_SEND) && (step_reg == STEP_EN_LO_B) && final_byte;
    end

endmodule

// File: design/lcdnw_dp.sv
module lcdnw_dp
    import lcdnw_pkg::*;
#(
    parameter int RS_BIT = RS_BIT_DEFAULT,
    parameter int EN_BIT = EN_BIT_DEFAULT
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  lcd_req_t    req,
    input  lcdnw_cmd_t  cmd,
    output lcdnw_stat_t stat,
    output logic        out_valid,
    input  logic        out_ready,
    output lcd_wr_t     out_data
);

    localparam logic [7:0] RS_MASK = 8'(1) << RS_BIT;
    localparam logic [7:0] EN_MASK = 8'(1) << EN_BIT;

    logic [7:0] latch_reg, latch_next;
    logic [7:0] value_reg;
    logic       row_reg;
    logic [3:0] column_reg;
    logic       out_valid_reg;
    lcd_wr_t    out_reg, out_next;
    logic [7:0] cur_byte;
    logic [14:0] final_wait;

    // Capture request fields
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            value_reg  <= req.value;
            row_reg    <= req.row;
            column_reg <= req.column;
        end
    end

    // Select the byte being sent
    always_comb
    begin
        case (cmd.op)
            OP_INIT:   cur_byte = init_byte(cmd.byte_idx);
            OP_SETPOS: cur_byte = (row_reg ? CMD_HOME_ROW1 : CMD_HOME_ROW0) |
                                  {4'd0, column_reg};
            OP_CLEAR:  cur_byte = (cmd.byte_idx == 3'd0) ? CMD_CLEAR : CMD_HOME_ROW0;
            default:   cur_byte = value_reg;
        endcase
        final_wait = ((cmd.op == OP_INIT || cmd.op == OP_CLEAR) && cur_byte == CMD_CLEAR)
                     ? WAIT_CLEAR : WAIT_BYTE;
    end

    // Next port latch and hold time for this step
    always_comb
    begin
        latch_next = latch_reg;
        out_next.wait_us = WAIT_NONE;
        if (cmd.power)
        begin
            out_next.wait_us = WAIT_POWER_ON;
        end
        else
        begin
            case (cmd.step)
                STEP_HI_NIBBLE:
                begin
                    latch_next = (latch_reg & LOW_MASK) | (cur_byte & NIBBLE_MASK);
                end
                STEP_RS:
                begin
                    if (cmd.op == OP_DATA)
                        latch_next = latch_reg | RS_MASK;
                    else
                        latch_next = latch_reg & ~RS_MASK;
                end
                STEP_EN_HI_A, STEP_EN_HI_B:
                begin
                    latch_next = latch_reg | EN_MASK;
                    out_next.wait_us = WAIT_PULSE;
                end
                STEP_EN_LO_A:
                begin
                    latch_next = latch_reg & ~EN_MASK;
                    out_next.wait_us = WAIT_NIBBLE;
                end
                STEP_LO_NIBBLE:
                begin
                    latch_next = (latch_reg & LOW_MASK) | {cur_byte[3:0], 4'd0};
                end
                STEP_EN_LO_B:
                begin
                    latch_next = latch_reg & ~EN_MASK;
                    out_next.wait_us = final_wait;
                end
                default:
                begin
                    latch_next = latch_reg;
                end
            endcase
        end
        out_next.port_value = latch_next;
        out_next.last       = cmd.last;
    end

    // Hold the port latch and the output stage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            latch_reg     <= 8'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.emit)
            begin
                latch_reg     <= latch_next;
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.emit)
            out_reg <= out_next;
    end

    assign stat.slot_free = !out_valid_reg || out_ready;
    assign out_valid      = out_valid_reg;
    assign out_data       = out_reg;

endmodule

// File: design/char_lcd_nibble_write_sequencer_unit.sv
// Character display 4-bit bus write sequencer. One request (command byte, data
// character, init, set position or clear) becomes a run of port writes: seven
// per byte sent, with the nibble on port bits 7..4, RS and EN on the bits set by
// RS_BIT and EN_BIT, and the hold time in microseconds beside each write.
// Init gives 50 writes (a power-on wait, then seven commands), clear gives 14,
// the others 7; unused operation codes are taken and give nothing. One write
// leaves per clock while out_ready stays high, through a single output register
// fed by the step counter of the controller; a new request is taken only once
// the last write of the previous one has entered that register.
module char_lcd_nibble_write_sequencer_unit
    import lcdnw_pkg::*;
#(
    parameter int RS_BIT = RS_BIT_DEFAULT,
    parameter int EN_BIT = EN_BIT_DEFAULT
)
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     in_valid,
    output logic     in_ready,
    input  lcd_req_t in_data,
    output logic     out_valid,
    input  logic     out_ready,
    output lcd_wr_t  out_data
);

    lcdnw_cmd_t  cmd;
    lcdnw_stat_t stat;

    // Sequence control
    lcdnw_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (in_valid),
        .req_op    (in_data.operation),
        .req_ready (in_ready),
        .stat      (stat),
        .cmd       (cmd)
    );

    // Port latch and output stage
    lcdnw_dp #(
        .RS_BIT (RS_BIT),
        .EN_BIT (EN_BIT)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (in_data),
        .cmd       (cmd),
        .stat      (stat),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

endmodule
